// ===== design/gbu_pkg.sv =====
package gbu_pkg;

    localparam int unsigned MAX_GLYPH_DIM = 255;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BITMAP = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    localparam logic [1:0] HDR_X_OFFSET = 2'd0;
    localparam logic [1:0] HDR_Y_OFFSET = 2'd1;
    localparam logic [1:0] HDR_WIDTH    = 2'd2;
    localparam logic [1:0] HDR_HEIGHT   = 2'd3;

    // One classified bitmap byte (or empty-glyph end) waiting to be serialised
    typedef struct packed {
        logic       is_pixel;
        logic [7:0] bits;
        logic [3:0] count;
        logic [7:0] base_col;
        logic [7:0] row;
        logic [7:0] x_offset;
        logic [7:0] y_offset;
        logic       last;
        logic [8:0] max_height;
    } cmd_t;

    typedef struct packed {
        logic       pixel_valid;
        logic       pixel_on;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] x_offset;
        logic [7:0] y_offset;
        logic       end_of_glyph;
        logic [8:0] max_height;
    } pix_t;

    function automatic logic [7:0] sat_dim(input logic [7:0] v);
        logic [7:0] lim;
        lim = 8'(MAX_GLYPH_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== design/gbu_front.sv =====
module gbu_front
    import gbu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_value,
    input  logic       start_of_glyph,
    output logic       push,
    output cmd_t       cmd
);

    logic [1:0] phase_reg, phase_next;
    logic [1:0] hidx_reg, hidx_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic [7:0] row_reg, row_next;
    logic [4:0] bir_reg, bir_next;
    logic [8:0] maxh_reg, maxh_next;

    logic [1:0] eff_phase;
    logic [1:0] eff_hidx;
    logic [7:0] sat_b;
    logic [9:0] total;
    logic [7:0] base;
    logic [7:0] left;
    logic [3:0] n;
    logic       last_byte;
    logic       last_row;

    assign eff_phase = start_of_glyph ? PH_HEADER : phase_reg;
    assign eff_hidx  = start_of_glyph ? HDR_X_OFFSET : hidx_reg;
    assign sat_b     = sat_dim(byte_value);
    assign total     = {{2{y_reg[7]}}, y_reg} + {2'b00, sat_b};

    assign base      = {bir_reg[4:0], 3'b000};
    assign left      = width_reg - base;
    assign last_byte = (left <= 8'd8);
    assign n         = last_byte ? left[3:0] : 4'd8;
    assign last_row  = ({1'b0, row_reg} + 9'd1) >= {1'b0, height_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        bir_next    = bir_reg;
        maxh_next   = maxh_reg;
        push        = 1'b0;
        cmd         = '0;
        cmd.x_offset = x_reg;
        cmd.y_offset = y_reg;

        if (accept)
        begin
            phase_next = eff_phase;
            case (eff_phase)
                PH_HEADER:
                begin
                    case (eff_hidx)
                        HDR_X_OFFSET: x_next = byte_value;
                        HDR_Y_OFFSET: y_next = byte_value;
                        HDR_WIDTH:    width_next = sat_b;
                        default:      height_next = sat_b;
                    endcase
                    if (eff_hidx != HDR_HEIGHT)
                    begin
                        hidx_next = eff_hidx + 2'd1;
                    end
                    else
                    begin
                        hidx_next = HDR_X_OFFSET;
                        // ignore negative or zero totals
                        if (!total[9] && (total[8:0] > maxh_reg))
                        begin
                            maxh_next = total[8:0];
                        end
                        row_next = '0;
                        bir_next = '0;
                        if (width_reg == 8'd0 || sat_b == 8'd0)
                        begin
                            phase_next     = PH_IDLE;
                            push           = 1'b1;
                            cmd.is_pixel   = 1'b0;
                            cmd.count      = 4'd1;
                            cmd.last       = 1'b1;
                            cmd.max_height = maxh_next;
                        end
                        else
                        begin
                            phase_next = PH_BITMAP;
                        end
                    end
                end
                PH_BITMAP:
                begin
                    push           = 1'b1;
                    cmd.is_pixel   = 1'b1;
                    cmd.bits       = byte_value;
                    cmd.count      = n;
                    cmd.base_col   = base;
                    cmd.row        = row_reg;
                    cmd.last       = last_row && last_byte;
                    cmd.max_height = maxh_reg;
                    if (last_byte)
                    begin
                        bir_next = '0;
                        if (last_row)
                        begin
                            row_next   = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            row_next = row_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        bir_next = bir_reg + 5'd1;
                    end
                end
                default:
                begin
                    // drop bytes until the next glyph start
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= HDR_X_OFFSET;
            x_reg      <= '0;
            y_reg      <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            row_reg    <= '0;
            bir_reg    <= '0;
            maxh_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            bir_reg    <= bir_next;
            maxh_reg   <= maxh_next;
        end
    end

endmodule

// ===== design/gbu_queue.sv =====
module gbu_queue
    import gbu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/gbu_back.sv =====
module gbu_back
    import gbu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  cmd_t head,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_pix
);

    logic [2:0] k_reg;
    logic       valid_reg;
    pix_t       pix_reg;
    pix_t       pix_next;
    logic       advance;
    logic       last_pix;

    assign advance  = head_valid && (!valid_reg || out_ready);
    assign last_pix = ({1'b0, k_reg} == (head.count - 4'd1));
    assign pop      = advance && last_pix;

    always_comb
    begin
        pix_next              = '0;
        pix_next.pixel_valid  = head.is_pixel;
        pix_next.pixel_on     = head.is_pixel & head.bits[3'd7 - k_reg];
        pix_next.column       = head.is_pixel ? (head.base_col + {5'b0, k_reg}) : 8'd0;
        pix_next.row          = head.row;
        pix_next.x_offset     = head.x_offset;
        pix_next.y_offset     = head.y_offset;
        pix_next.end_of_glyph = head.last && last_pix;
        pix_next.max_height   = head.max_height;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                k_reg     <= last_pix ? 3'd0 : k_reg + 3'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// ===== design/glyph_bitmap_unpacker.sv =====
// Channel   | Signals                          | Item
// ----------+----------------------------------+--------------------------------------
// s (in)    | s_tvalid s_tready s_tdata s_tuser| one glyph record byte
// m (out)   | m_tvalid m_tready m_tdata m_tuser| one pixel or empty-glyph end
//           | m_tlast                          |
// A byte is taken every cycle while the four-entry command queue has room;
// header bytes are parsed in the cycle they arrive.
// The serialiser drains one pixel per cycle unless m_tready stalls it, so a
// bitmap byte holds it for its one to eight pixels and the sustained rate
// is set there. Each byte passes the queue, then the output register.
// rst_n clears parser, queue and output state asynchronously.
// Output stalls back up into the queue, then into s_tready.
module glyph_bitmap_unpacker
    import gbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] start_of_glyph
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] pixel_on, [8:1] column, [16:9] row,
                                   // [24:17] glyph_x_offset, [32:25] glyph_y_offset,
                                   // [41:33] running_max_height, [47:42] zero
    output logic        m_tuser,   // [0] pixel_valid
    output logic        m_tlast    // end_of_glyph
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic head_valid;
    cmd_t head;
    logic pop;
    pix_t pix;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    gbu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .byte_value     (s_tdata),
        .start_of_glyph (s_tuser),
        .push           (push),
        .cmd            (push_cmd)
    );

    gbu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    gbu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (pix)
    );

    assign m_tdata = {6'b0, pix.max_height, pix.y_offset, pix.x_offset,
                      pix.row, pix.column, pix.pixel_on};
    assign m_tuser = pix.pixel_valid;
    assign m_tlast = pix.end_of_glyph;

endmodule

// ===== tb/gbu_pixel_checker.sv =====
module gbu_pixel_checker
    import gbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] start_of_glyph
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [0] pixel_on, [8:1] column, [16:9] row,
                                   // [24:17] glyph_x_offset, [32:25] glyph_y_offset,
                                   // [41:33] running_max_height, [47:42] zero
    input  logic        m_tuser,   // [0] pixel_valid
    input  logic        m_tlast,   // end_of_glyph
    output int          mismatches,
    output int          pending
);

    localparam int MAX_REPORTS = 40;

    // Shadow copy of the parser
    logic [1:0] phase    = PH_HEADER;
    logic [1:0] hdr_idx  = HDR_X_OFFSET;
    logic [7:0] x_off    = '0;
    logic [7:0] y_off    = '0;
    logic [7:0] g_width  = '0;
    logic [7:0] g_height = '0;
    logic [7:0] row_cnt  = '0;
    logic [4:0] byte_idx = '0;
    logic [8:0] max_h    = '0;

    pix_t pixel_q[$];
    int   err_total = 0;
    int   q_level   = 0;

    assign mismatches = err_total;
    assign pending    = q_level;

    function automatic logic [7:0] dim_limit(input logic [7:0] v);
        return (int'(v) > int'(MAX_GLYPH_DIM)) ? 8'(MAX_GLYPH_DIM) : v;
    endfunction

    task automatic note_mismatch(input string msg);
        if (err_total < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
        err_total++;
    endtask

    task automatic push_pixel(input logic valid, input logic on, input logic [7:0] col,
                              input logic [7:0] row, input logic last);
        pix_t px;
        px.pixel_valid  = valid;
        px.pixel_on     = on;
        px.column       = col;
        px.row          = row;
        px.x_offset     = x_off;
        px.y_offset     = y_off;
        px.end_of_glyph = last;
        px.max_height   = max_h;
        pixel_q.push_back(px);
    endtask

    task automatic unpack_byte(input logic [7:0] b, input logic st);
        int   base;
        int   left;
        int   n;
        int   total;
        int   k;
        logic last_row;
        logic last_byte;
        // start always restarts the header, dropping any glyph in flight
        if (st)
        begin
            phase   = PH_HEADER;
            hdr_idx = HDR_X_OFFSET;
        end
        if (phase == PH_HEADER)
        begin
            case (hdr_idx)
                HDR_X_OFFSET: x_off = b;
                HDR_Y_OFFSET: y_off = b;
                HDR_WIDTH:    g_width = dim_limit(b);
                default:      g_height = dim_limit(b);
            endcase
            if (hdr_idx != HDR_HEIGHT)
            begin
                hdr_idx = hdr_idx + 2'd1;
                return;
            end
            hdr_idx = HDR_X_OFFSET;
            // negative totals never lower or set the maximum
            total = int'($signed(y_off)) + int'(g_height);
            if (total > 0 && total > int'(max_h))
                max_h = 9'(total);
            row_cnt  = '0;
            byte_idx = '0;
            if (g_width == 0 || g_height == 0)
            begin
                phase = PH_IDLE;
                push_pixel(1'b0, 1'b0, 8'd0, 8'd0, 1'b1);
            end
            else
                phase = PH_BITMAP;
        end
        else if (phase == PH_BITMAP)
        begin
            base      = int'(byte_idx) * 8;
            left      = int'(g_width) - base;
            n         = (left > 8) ? 8 : left;
            last_row  = (int'(row_cnt) + 1 >= int'(g_height));
            last_byte = (base + n >= int'(g_width));
            for (k = 0; k < n; k++)
                push_pixel(1'b1, b[7 - k], 8'(base + k), row_cnt,
                           last_row && last_byte && (k + 1 == n));
            if (last_byte)
            begin
                byte_idx = '0;
                if (last_row)
                begin
                    row_cnt = '0;
                    phase   = PH_IDLE;
                end
                else
                    row_cnt = row_cnt + 8'd1;
            end
            else
                byte_idx = byte_idx + 5'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic check_pixel();
        pix_t want;
        if (pixel_q.size() == 0)
        begin
            note_mismatch($sformatf("pixel item with nothing expected (tdata 0x%0h)", m_tdata));
            return;
        end
        want = pixel_q.pop_front();
        check_field("pixel_valid", 9'(m_tuser), 9'(want.pixel_valid));
        check_field("pixel_on", 9'(m_tdata[0]), 9'(want.pixel_on));
        check_field("column", 9'(m_tdata[8:1]), 9'(want.column));
        check_field("row", 9'(m_tdata[16:9]), 9'(want.row));
        check_field("glyph_x_offset", 9'(m_tdata[24:17]), 9'(want.x_offset));
        check_field("glyph_y_offset", 9'(m_tdata[32:25]), 9'(want.y_offset));
        check_field("end_of_glyph", 9'(m_tlast), 9'(want.end_of_glyph));
        check_field("running_max_height", m_tdata[41:33], want.max_height);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_HEADER;
            hdr_idx  = HDR_X_OFFSET;
            x_off    = '0;
            y_off    = '0;
            g_width  = '0;
            g_height = '0;
            row_cnt  = '0;
            byte_idx = '0;
            max_h    = '0;
            pixel_q.delete();
        end
        else
        begin
            // predict first so the oldest expectation is always at the front
            if (s_tvalid && s_tready)
                unpack_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_pixel();
        end
        q_level = pixel_q.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import gbu_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_START     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int RANDOM_ITEMS   = 120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] byte_value
    logic        s_tuser;    // [0] start_of_glyph
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [0] pixel_on, [8:1] column, [16:9] row,
                             // [24:17] glyph_x_offset, [32:25] glyph_y_offset,
                             // [41:33] running_max_height, [47:42] zero
    logic        m_tuser;    // [0] pixel_valid
    logic        m_tlast;    // end_of_glyph

    int mismatches;
    int pending_px;
    int burst_left   = 0;
    int byte_count   = 0;
    int stall_cycles = 0;

    glyph_bitmap_unpacker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    gbu_pixel_checker pixel_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending_px)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one item and hold it until taken; gaps fall between bursts
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        byte_count++;
        @(negedge clk);
    endtask

    // Header then random bitmap; 0 <= cut < bitmap bytes truncates the bitmap
    task automatic send_glyph(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
                              input logic [7:0] h, input logic st, input int cut);
        int nbytes;
        nbytes = ((int'(w) + 7) / 8) * int'(h);
        if (cut >= 0 && cut < nbytes)
            nbytes = cut;
        send_byte(x, st);
        send_byte(y, 1'b0);
        send_byte(w, 1'b0);
        send_byte(h, 1'b0);
        repeat (nbytes) send_byte(8'($urandom), 1'b0);
    endtask

    function automatic logic [7:0] pick_width();
        return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
    endfunction

    function automatic logic [7:0] pick_height();
        return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
    endfunction

    // Receiver: a long hold-off early on to fill the block, then mixed patterns
    initial
    begin
        int mode;
        int len;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (HOLD_START)
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 2) != 0);
        end
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        forever
        begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** glyph_bitmap_unpacker: FAILED **");
            $finish;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int kind;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first record after reset parses without start; total height negative
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'h80, 1'b0);
        // zero width gives the empty end item
        send_glyph(8'h80, 8'h7F, 8'd0, 8'd5, 1'b1, -1);
        // idle bytes are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart in the middle of a bitmap
        send_glyph(8'h00, 8'h05, 8'd10, 8'd2, 1'b1, 1);
        // zero height
        send_glyph(8'h10, 8'hF0, 8'd3, 8'd0, 1'b1, -1);
        // two bytes per row with padding
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'd9, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);

        // widest row, then the tallest glyph at the largest total height, cut short
        send_glyph(8'($urandom), 8'($urandom), 8'd255, 8'd1, 1'b1, -1);
        send_glyph(8'($urandom), 8'h7F, 8'($urandom_range(1, 8)), 8'd255, 1'b1, 8);

        byte_count = 0;
        while (byte_count < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                send_glyph(8'($urandom), 8'($urandom), pick_width(), pick_height(),
                           1'b1, -1);
            else if (kind == 7)
                send_glyph(8'($urandom), 8'($urandom), pick_width(), pick_height(),
                           1'b1, $urandom_range(0, 3));
            else if (kind == 8)
                send_glyph(8'($urandom), 8'($urandom), pick_width(), pick_height(),
                           1'b0, -1);
            else
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        end
        s_tvalid <= 1'b0;

        while (pending_px != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("** glyph_bitmap_unpacker: PASSED **");
        else
            $display("** glyph_bitmap_unpacker: FAILED **");
        $finish;
    end

endmodule
